// ----- rtl/bfs_pkg.sv -----
// Package for the breadth-first search block: sizes, command codes and sequencer states.
package bfs_pkg;

	localparam int MAX_NODES = 64;
	localparam int NODE_W    = 6;
	localparam int COUNT_W   = 7;
	localparam int PTR_W     = $clog2(MAX_NODES);

	localparam logic [COUNT_W-1:0] NODE_COUNT_RST = COUNT_W'(64);
	localparam logic [COUNT_W-1:0] MAX_COUNT      = COUNT_W'(MAX_NODES);

	typedef logic [MAX_NODES-1:0] row_t;

	typedef enum logic [1:0] {
		CMD_ADD_EDGE = 2'd0,
		CMD_SEARCH   = 2'd1,
		CMD_CLEAR    = 2'd2,
		CMD_UNUSED   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EDGE_WR,
		ST_BAD,
		ST_POP,
		ST_FETCH,
		ST_LOAD,
		ST_SCAN,
		ST_EMIT
	} state_t;

	// Index of the lowest set bit; zero when the word is empty.
	function automatic logic [NODE_W-1:0] lowest_set(input row_t v);
		logic [NODE_W-1:0] idx;
		idx = '0;
		for (int i = MAX_NODES - 1; i >= 0; i--) begin
			if (v[i]) begin
				idx = NODE_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

// ----- rtl/bfs_adjacency_matrix.sv -----
// Adjacency bit matrix with a breadth-first search sequencer around one lowest-set-bit finder.
// Add edge: row read, then row write. Clear empties the row valid bits as the beat is taken.
// Bad start: the result goes through ST_BAD to the output register. Search: per visited node
// pop, fetch, load, one scan step per enqueued neighbor and emit; a result waiting on out_ready
// stalls it. Reset clears the row valid bits, visited map and queue pointers, sets node_count
// to 64, and needs no clearing pass. A new beat is taken only in idle.
module bfs_adjacency_matrix
	import bfs_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wen,
	input  logic [COUNT_W-1:0] cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         cmd,
	input  logic [NODE_W-1:0]  src_node,
	input  logic [NODE_W-1:0]  dst_node,
	input  logic [NODE_W-1:0]  start_node,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [NODE_W-1:0]  visited_node,
	output logic               last,
	output logic               bad_start
);

	state_t state_q, state_d;

	logic [COUNT_W-1:0] node_count_q;
	logic [COUNT_W-1:0] eff_n;
	row_t               range_mask;

	// Adjacency memory and per-row valid bits.
	row_t               adj_mem [MAX_NODES];
	row_t               adj_rd_q;
	logic               adj_rd_vld_q;
	row_t               row_vld_q;
	logic [PTR_W-1:0]   adj_raddr;

	// Queue memory.
	logic [NODE_W-1:0]  queue_mem [MAX_NODES];
	logic [NODE_W-1:0]  q_rd_q;
	logic [PTR_W-1:0]   head_q, tail_q;
	logic [COUNT_W-1:0] qcount_q;

	row_t               visited_q;
	row_t               cand_q;
	logic [NODE_W-1:0]  cur_q;
	logic [NODE_W-1:0]  src_q, dst_q;
	logic [NODE_W-1:0]  pick;

	logic               out_valid_q;
	logic [NODE_W-1:0]  out_node_q;
	logic               out_last_q;
	logic               out_bad_q;
	logic               out_free;
	logic               accept;
	logic               start_ok, edge_ok;

	assign eff_n      = (node_count_q > MAX_COUNT) ? MAX_COUNT : node_count_q;
	assign range_mask = (row_t'(1) << eff_n) - row_t'(1);
	assign out_free   = !out_valid_q || out_ready;
	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign start_ok   = COUNT_W'(start_node) < eff_n;
	assign edge_ok    = (COUNT_W'(src_node) < eff_n) && (COUNT_W'(dst_node) < eff_n);
	assign pick       = lowest_set(cand_q);
	assign adj_raddr  = (state_q == ST_FETCH) ? PTR_W'(q_rd_q) : PTR_W'(src_node);

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(MAX_NODES - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (cmd_t'(cmd))
						CMD_ADD_EDGE: state_d = edge_ok ? ST_EDGE_WR : ST_IDLE;
						CMD_SEARCH:   state_d = start_ok ? ST_POP : ST_BAD;
						CMD_CLEAR:    state_d = ST_IDLE;
						CMD_UNUSED:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_EDGE_WR: state_d = ST_IDLE;
			ST_BAD:     state_d = out_free ? ST_IDLE : ST_BAD;
			ST_POP:     state_d = ST_FETCH;
			ST_FETCH:   state_d = ST_LOAD;
			ST_LOAD:    state_d = ST_SCAN;
			ST_SCAN:    state_d = (cand_q == '0) ? ST_EMIT : ST_SCAN;
			ST_EMIT: begin
				if (out_free) begin
					state_d = (qcount_q == '0) ? ST_IDLE : ST_POP;
				end
			end
			default:    state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODE_COUNT_RST;
		end else if (cfg_wen) begin
			node_count_q <= cfg_wdata;
		end
	end

	// Memory ports: registered reads, one write per cycle.
	always_ff @(posedge clk) begin
		adj_rd_q <= adj_mem[adj_raddr];
		q_rd_q   <= queue_mem[head_q];
		if (state_q == ST_EDGE_WR) begin
			adj_mem[PTR_W'(src_q)] <= (adj_rd_vld_q ? adj_rd_q : '0) | (row_t'(1) << dst_q);
		end
		if (accept && cmd_t'(cmd) == CMD_SEARCH && start_ok) begin
			queue_mem[tail_q] <= start_node;
		end else if (state_q == ST_SCAN && cand_q != '0) begin
			queue_mem[tail_q] <= pick;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q    <= '0;
			adj_rd_vld_q <= 1'b0;
		end else begin
			adj_rd_vld_q <= row_vld_q[adj_raddr];
			if (accept && cmd_t'(cmd) == CMD_CLEAR) begin
				row_vld_q <= '0;
			end else if (state_q == ST_EDGE_WR) begin
				row_vld_q[PTR_W'(src_q)] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			src_q <= src_node;
			dst_q <= dst_node;
		end
		if (state_q == ST_FETCH) begin
			cur_q <= q_rd_q;
		end
		if (state_q == ST_LOAD) begin
			cand_q <= (adj_rd_vld_q ? adj_rd_q : '0) & ~visited_q & range_mask;
		end else if (state_q == ST_SCAN) begin
			cand_q[pick] <= 1'b0;
		end
	end

	// Queue pointers and the visited map.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			tail_q    <= '0;
			qcount_q  <= '0;
			visited_q <= '0;
		end else begin
			if (accept && cmd_t'(cmd) == CMD_SEARCH && start_ok) begin
				visited_q <= row_t'(1) << start_node;
				tail_q    <= ptr_next(tail_q);
				qcount_q  <= COUNT_W'(1);
			end else if (state_q == ST_POP) begin
				head_q   <= ptr_next(head_q);
				qcount_q <= qcount_q - COUNT_W'(1);
			end else if (state_q == ST_SCAN && cand_q != '0) begin
				visited_q[pick] <= 1'b1;
				tail_q          <= ptr_next(tail_q);
				qcount_q        <= qcount_q + COUNT_W'(1);
			end
		end
	end

	// Output register; the last beat of a search is the one that leaves the queue empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= (state_q == ST_BAD) || (state_q == ST_EMIT);
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (state_q == ST_BAD) begin
				out_node_q <= '0;
				out_last_q <= 1'b1;
				out_bad_q  <= 1'b1;
			end else if (state_q == ST_EMIT) begin
				out_node_q <= cur_q;
				out_last_q <= (qcount_q == '0);
				out_bad_q  <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign visited_node = out_node_q;
	assign last         = out_last_q;
	assign bad_start    = out_bad_q;

endmodule
